@@ rtl/core/fenwick_tree_engine_unit_assert.svh @@
// Assertion macros of the Fenwick tree engine RTL, used by fte_ctrl.
// Define ASSERT_OFF to compile every check away; no other dependencies.
`ifndef FENWICK_TREE_ENGINE_UNIT_ASSERT_SVH
`define FENWICK_TREE_ENGINE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Clocked check that is ignored while reset is asserted.
`define FTE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also covers the reset cycles.
`define FTE_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FTE_ASSERT(lbl, clk, rst_n, prop, msg)
`define FTE_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/core/fte_pkg.sv @@
// Shared types and constants of the Fenwick tree engine.
// No dependencies; the interfaces, top level, controller and datapath import it.
package fte_pkg;

  // Fixed field widths.
  localparam int KIND_W = 2;
  localparam int POS_W  = 10;
  localparam int DATA_W = 32;
  localparam int USED_W = 11;

  // Active size after reset.
  localparam logic [USED_W-1:0] USED_RESET = 11'd1024;

  // Operation codes.
  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SUM    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;  // write zero at the clear pointer and advance it
    logic load;      // capture an input beat and set up the walk
    logic add_wr;    // write back entry plus delta, climb to the parent
    logic pre_acc;   // fold entry into the range total, drop the low bit
    logic pre_next;  // start the second (subtracted) prefix walk
    logic rd_srch;   // read address comes from the search step
    logic srch_cmp;  // compare entry with the remaining target
    logic bit_dec;   // move the search to the next lower bit
    logic out_load;  // load the result register
  } fte_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;  // clear pointer is on the last entry
    logic add_go;    // add walk index still inside the active size
    logic pre_go;    // prefix walk index is not yet zero
    logic phase;     // second prefix walk is running
    logic srch_ok;   // search step lies inside the active size
    logic bit_zero;  // search is on its last bit
  } fte_stat_t;

endpackage

@@ rtl/core/fte_if.sv @@
// Valid/ready channel interfaces of the Fenwick tree engine.
// Depends on fte_pkg for the field widths.
interface fte_in_if;
  import fte_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [POS_W-1:0]         position;
  logic [POS_W-1:0]         position_end;
  logic signed [DATA_W-1:0] delta;
  logic signed [DATA_W-1:0] target;
  modport source (output valid, kind, position, position_end, delta, target, input ready);
  modport sink   (input valid, kind, position, position_end, delta, target, output ready);
endinterface

interface fte_out_if;
  import fte_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result;
  modport source (output valid, result, input ready);
  modport sink   (input valid, result, output ready);
endinterface

interface fte_cfg_if;
  import fte_pkg::*;
  logic              valid;
  logic              ready;
  logic [USED_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ rtl/core/fenwick_tree_engine_unit.sv @@
// Fenwick tree engine top level: each tree node read takes an address state, then a state
// that uses the registered read data; a search step outside the active size skips the
// compare state. A range sum or search result is offered the cycle after S_DONE finds the
// output slot free; input beats are taken meanwhile. After reset a clearing pass zeroes the
// store with in_ready low; register writes are taken at all times. Depends on fte_pkg,
// fte_if, fte_ctrl, fte_datapath.
module fenwick_tree_engine_unit #(
  parameter int TREE_SIZE = 1024,
  parameter int LOG_SIZE  = 10
) (
  input  logic      clk,
  input  logic      rst_n,
  fte_cfg_if.sink   cfg_beat,
  fte_in_if.sink    in_beat,
  fte_out_if.source out_beat
);
  import fte_pkg::*;

  fte_cmd_t  cmd;
  fte_stat_t stat;

  // Sequencer.
  fte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_beat.valid),
    .in_kind   (in_beat.kind),
    .in_ready  (in_beat.ready),
    .out_valid (out_beat.valid),
    .out_ready (out_beat.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Store and arithmetic.
  fte_datapath #(
    .TREE_SIZE (TREE_SIZE),
    .LOG_SIZE  (LOG_SIZE)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_beat.valid),
    .cfg_data        (cfg_beat.data),
    .cfg_ready       (cfg_beat.ready),
    .in_kind         (in_beat.kind),
    .in_position     (in_beat.position),
    .in_position_end (in_beat.position_end),
    .in_delta        (in_beat.delta),
    .in_target       (in_beat.target),
    .out_result      (out_beat.result),
    .cmd             (cmd),
    .stat            (stat)
  );

endmodule

@@ rtl/core/fte_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; a read of the address being
  // written returns the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/fte_ctrl.sv @@
// Controller of the Fenwick tree engine: sequences clear, add, range sum
// and search walks. Depends on fte_pkg and the assertion macro header.
`include "fenwick_tree_engine_unit_assert.svh"
module fte_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [fte_pkg::KIND_W-1:0]  in_kind,
  output logic                        in_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  input  fte_pkg::fte_stat_t          stat,
  output fte_pkg::fte_cmd_t           cmd
);
  import fte_pkg::*;

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_ADD_RD   = 4'd2;
  localparam logic [3:0] S_ADD_WR   = 4'd3;
  localparam logic [3:0] S_PRE_RD   = 4'd4;
  localparam logic [3:0] S_PRE_ACC  = 4'd5;
  localparam logic [3:0] S_SRCH_RD  = 4'd6;
  localparam logic [3:0] S_SRCH_CMP = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_kind)
            KIND_ADD:    state_nxt = S_ADD_RD;
            KIND_SUM:    state_nxt = S_PRE_RD;
            KIND_SEARCH: state_nxt = S_SRCH_RD;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD_RD: begin
        state_nxt = stat.add_go ? S_ADD_WR : S_IDLE;
      end
      S_ADD_WR: begin
        cmd.add_wr = 1'b1;
        state_nxt  = S_ADD_RD;
      end
      S_PRE_RD: begin
        if (stat.pre_go) begin
          state_nxt = S_PRE_ACC;
        end else if (!stat.phase) begin
          cmd.pre_next = 1'b1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_PRE_ACC: begin
        cmd.pre_acc = 1'b1;
        state_nxt   = S_PRE_RD;
      end
      S_SRCH_RD: begin
        cmd.rd_srch = 1'b1;
        if (stat.srch_ok) begin
          state_nxt = S_SRCH_CMP;
        end else if (stat.bit_zero) begin
          state_nxt = S_DONE;
        end else begin
          cmd.bit_dec = 1'b1;
        end
      end
      S_SRCH_CMP: begin
        cmd.srch_cmp = 1'b1;
        if (stat.bit_zero) begin
          state_nxt = S_DONE;
        end else begin
          cmd.bit_dec = 1'b1;
          state_nxt   = S_SRCH_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // The output slot fills on a load and empties when its beat is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // State registers; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // Reset always leads into the clearing pass with an empty output slot.
  `FTE_ASSERT_NR(a_reset_clear, clk, !rst_n |=> (state_r == S_CLEAR && !out_valid_r), "reset did not start the clearing pass")
  // A finished result waits while the output slot is still occupied.
  `FTE_ASSERT(a_done_hold, clk, rst_n, (state_r == S_DONE && out_valid_r && !out_ready) |=> (state_r == S_DONE), "result left before the output slot was free")
  // A result appears only at the end of a range sum or search.
  `FTE_ASSERT(a_out_src, clk, rst_n, $rose(out_valid_r) |-> ($past(state_r) == S_DONE), "result shown without a finished operation")

endmodule

@@ rtl/core/fte_datapath.sv @@
// Datapath of the Fenwick tree engine: tree store, walk index, totals,
// search registers and result register. Depends on fte_pkg and fte_ram.
module fte_datapath #(
  parameter int TREE_SIZE = 1024,
  parameter int LOG_SIZE  = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [fte_pkg::USED_W-1:0]        cfg_data,
  output logic                              cfg_ready,
  input  logic [fte_pkg::KIND_W-1:0]        in_kind,
  input  logic [fte_pkg::POS_W-1:0]         in_position,
  input  logic [fte_pkg::POS_W-1:0]         in_position_end,
  input  logic signed [fte_pkg::DATA_W-1:0] in_delta,
  input  logic signed [fte_pkg::DATA_W-1:0] in_target,
  output logic signed [fte_pkg::DATA_W-1:0] out_result,
  input  fte_pkg::fte_cmd_t                 cmd,
  output fte_pkg::fte_stat_t                stat
);
  import fte_pkg::*;

  // Address, walk index, search and bit counter widths.
  localparam int AW  = (TREE_SIZE > 1) ? $clog2(TREE_SIZE) : 1;
  localparam int IW  = $clog2(TREE_SIZE + 1);
  localparam int IW2 = (IW > USED_W) ? IW : USED_W;
  localparam int WW  = ((IW2 > POS_W + 1) ? IW2 : POS_W + 1) + 1;
  localparam int KW  = (WW > LOG_SIZE + 2) ? WW : LOG_SIZE + 2;
  localparam int BW  = (LOG_SIZE > 0) ? $clog2(LOG_SIZE + 1) : 1;

  logic [USED_W-1:0] used_r;
  logic [KIND_W-1:0] kind_r;
  logic [POS_W-1:0]  pos_r;
  logic [DATA_W-1:0] delta_r;
  logic [DATA_W-1:0] rest_r;
  logic [DATA_W-1:0] acc_r;
  logic [WW-1:0]     idx_r;
  logic [KW-1:0]     k_r;
  logic [BW-1:0]     bit_r;
  logic              phase_r;
  logic [AW-1:0]     clr_cnt_r;
  logic [DATA_W-1:0] out_r;

  logic [WW-1:0]     m_w;
  logic [WW-1:0]     low_w;
  logic [WW-1:0]     idx_m1;
  logic [KW-1:0]     step_w;
  logic [KW-1:0]     step_m1;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  // Prefix lengths beyond the store stop at the store size.
  function automatic logic [WW-1:0] sat_len(input logic [WW-1:0] n);
    sat_len = (n > WW'(TREE_SIZE)) ? WW'(TREE_SIZE) : n;
  endfunction

  // Active size, lowest set bit of the walk index and the search step.
  assign m_w     = (WW'(used_r) > WW'(TREE_SIZE)) ? WW'(TREE_SIZE) : WW'(used_r);
  assign low_w   = idx_r & (~idx_r + WW'(1));
  assign idx_m1  = idx_r - WW'(1);
  assign step_w  = k_r + (KW'(1) << bit_r);
  assign step_m1 = step_w - KW'(1);

  // Store ports: the clearing pass and add write-back share the write port.
  assign mem_raddr = cmd.rd_srch ? step_m1[AW-1:0] : idx_m1[AW-1:0];
  assign mem_we    = cmd.clr_step | cmd.add_wr;
  assign mem_waddr = cmd.clr_step ? clr_cnt_r : idx_m1[AW-1:0];
  assign mem_wdata = cmd.clr_step ? '0 : mem_rdata + delta_r;

  fte_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TREE_SIZE)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Status back to the controller.
  assign stat.clr_last = (clr_cnt_r == AW'(TREE_SIZE - 1));
  assign stat.add_go   = (idx_r <= m_w);
  assign stat.pre_go   = (idx_r != '0);
  assign stat.phase    = phase_r;
  assign stat.srch_ok  = (step_w <= KW'(m_w));
  assign stat.bit_zero = (bit_r == '0);

  // The register port is always ready.
  assign cfg_ready = 1'b1;

  // Control registers: active size, clear pointer, walk phase, bit counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= USED_RESET;
      clr_cnt_r <= '0;
      phase_r   <= 1'b0;
      bit_r     <= '0;
    end else begin
      if (cfg_valid) used_r <= cfg_data;
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (cmd.load) begin
        phase_r <= 1'b0;
        bit_r   <= BW'(LOG_SIZE);
      end else begin
        if (cmd.pre_next) phase_r <= 1'b1;
        if (cmd.bit_dec) bit_r <= bit_r - BW'(1);
      end
    end
  end

  // Walk registers and totals.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_kind;
      pos_r   <= in_position;
      delta_r <= in_delta;
      rest_r  <= in_target;
      acc_r   <= '0;
      k_r     <= '0;
      if (in_kind == KIND_ADD) begin
        idx_r <= WW'(in_position) + WW'(1);
      end else begin
        idx_r <= sat_len(WW'(in_position_end) + WW'(1));
      end
    end else begin
      if (cmd.add_wr) idx_r <= idx_r + low_w;
      if (cmd.pre_next) idx_r <= sat_len(WW'(pos_r));
      if (cmd.pre_acc) begin
        acc_r <= phase_r ? (acc_r - mem_rdata) : (acc_r + mem_rdata);
        idx_r <= idx_r - low_w;
      end
      // Greedy descent: take the step when its entry is below what remains.
      if (cmd.srch_cmp && ($signed(mem_rdata) < $signed(rest_r))) begin
        k_r    <= step_w;
        rest_r <= rest_r - mem_rdata;
      end
    end
  end

  // Result register: prefix length for search, range total otherwise.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r <= (kind_r == KIND_SEARCH) ? DATA_W'(k_r) : acc_r;
    end
  end

  assign out_result = $signed(out_r);

endmodule
